// File: hw/rtl/compact_length_prefix_codec_assert.svh
// Assertion macros for the length prefix codec
`ifndef COMPACT_LENGTH_PREFIX_CODEC_ASSERT_SVH
`define COMPACT_LENGTH_PREFIX_CODEC_ASSERT_SVH
`ifndef SYNTHESIS
`define CLPC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: check failed");
`define CLPC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define CLPC_ASSERT(lbl, clk, rstn, prop)
`define CLPC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/clpc_pkg.sv
// Shared types and constants of the length prefix codec
`default_nettype none
package clpc_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] FMT_COMPACT = 2'd0;
    localparam logic [1:0] FMT_LE      = 2'd1;
    localparam logic [1:0] FMT_BE      = 2'd2;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic [7:0] TAG_WIDE = 8'hE0;

    // One result run: cnt bytes taken MSB first from data
    typedef struct packed {
        logic [39:0] data;
        logic [2:0]  cnt;
        logic [31:0] value;
        logic        value_valid;
        logic        header_error;
    } job_t;

endpackage
`default_nettype wire

// File: hw/rtl/clpc_front.sv
// Front end: takes transfers, builds encode runs and tracks decoder state
`default_nettype none
module clpc_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_func,
    input  wire logic [31:0]   s_value_in,
    input  wire logic [7:0]    s_byte_in,
    input  wire logic          cfg_wr_en,
    input  wire logic [1:0]    cfg_wr_data,
    input  wire logic          q_full,
    output logic               q_push,
    output clpc_pkg::job_t     q_job
);

    logic [1:0]  fmt_reg;
    logic [2:0]  pend_reg, pend_next;
    logic [31:0] acc_reg, acc_next;
    logic        accept;
    logic        dec_emit;
    logic [31:0] dec_value;
    logic        dec_err;
    logic [31:0] acc_shift;
    logic [31:0] enc_word;
    clpc_pkg::job_t enc_job, dec_job;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign acc_shift = {acc_reg[23:0], s_byte_in};

    // Encoder: pick the run by format and magnitude
    always_comb begin
        enc_word = s_value_in;
        enc_job  = '0;
        priority if (fmt_reg == clpc_pkg::FMT_LE) begin
            enc_job.data = {s_value_in[7:0], s_value_in[15:8],
                            s_value_in[23:16], s_value_in[31:24], 8'h00};
            enc_job.cnt  = 3'd4;
        end else if (fmt_reg != clpc_pkg::FMT_COMPACT) begin
            enc_job.data = {s_value_in, 8'h00};
            enc_job.cnt  = 3'd4;
        end else if (s_value_in < 32'h0000_0080) begin
            enc_job.data = {s_value_in[7:0], 32'h0};
            enc_job.cnt  = 3'd1;
        end else if (s_value_in < 32'h0000_4000) begin
            enc_word     = s_value_in | 32'h0000_8000;
            enc_job.data = {enc_word[15:0], 24'h0};
            enc_job.cnt  = 3'd2;
        end else if (s_value_in < 32'h2000_0000) begin
            enc_word     = s_value_in | 32'hC000_0000;
            enc_job.data = {enc_word, 8'h00};
            enc_job.cnt  = 3'd4;
        end else begin
            enc_job.data = {clpc_pkg::TAG_WIDE, s_value_in};
            enc_job.cnt  = 3'd5;
        end
    end

    // Decoder state update
    always_comb begin
        pend_next = pend_reg;
        acc_next  = acc_reg;
        dec_emit  = 1'b0;
        dec_value = '0;
        dec_err   = 1'b0;
        if (fmt_reg == clpc_pkg::FMT_COMPACT) begin
            if (pend_reg == 3'd0) begin
                priority if (s_byte_in[7] == 1'b0) begin
                    dec_emit  = 1'b1;
                    dec_value = {24'h0, s_byte_in};
                    acc_next  = '0;
                end else if (s_byte_in[7:6] == 2'b10) begin
                    acc_next  = {26'h0, s_byte_in[5:0]};
                    pend_next = 3'd1;
                end else if (s_byte_in[7:5] == 3'b110) begin
                    acc_next  = {27'h0, s_byte_in[4:0]};
                    pend_next = 3'd3;
                end else if (s_byte_in[7:4] == 4'b1110) begin
                    acc_next  = '0;
                    pend_next = 3'd4;
                end else begin
                    acc_next  = '0;
                    dec_emit  = 1'b1;
                    dec_err   = 1'b1;
                end
            end else if (pend_reg == 3'd1) begin
                dec_emit  = 1'b1;
                dec_value = acc_shift;
                acc_next  = '0;
                pend_next = 3'd0;
            end else begin
                acc_next  = acc_shift;
                pend_next = pend_reg - 3'd1;
            end
        end else if (pend_reg == 3'd0 || pend_reg > 3'd3) begin
            acc_next  = {24'h0, s_byte_in};
            pend_next = 3'd3;
        end else begin
            if (fmt_reg == clpc_pkg::FMT_LE) begin
                unique case (pend_reg)
                    3'd3:    acc_next = acc_reg | {16'h0, s_byte_in, 8'h0};
                    3'd2:    acc_next = acc_reg | {8'h0, s_byte_in, 16'h0};
                    default: acc_next = acc_reg | {s_byte_in, 24'h0};
                endcase
            end else begin
                acc_next = acc_shift;
            end
            pend_next = pend_reg - 3'd1;
            if (pend_reg == 3'd1) begin
                dec_emit  = 1'b1;
                dec_value = acc_next;
                acc_next  = '0;
            end
        end
    end

    always_comb begin
        dec_job              = '0;
        dec_job.cnt          = 3'd1;
        dec_job.value        = dec_value;
        dec_job.value_valid  = !dec_err;
        dec_job.header_error = dec_err;
    end

    assign q_push = accept && (s_func == clpc_pkg::FUNC_ENCODE || dec_emit);
    assign q_job  = (s_func == clpc_pkg::FUNC_ENCODE) ? enc_job : dec_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg  <= clpc_pkg::FMT_COMPACT;
            pend_reg <= '0;
            acc_reg  <= '0;
        end else if (cfg_wr_en) begin
            fmt_reg  <= cfg_wr_data;
            pend_reg <= '0;
            acc_reg  <= '0;
        end else if (accept && s_func == clpc_pkg::FUNC_DECODE) begin
            pend_reg <= pend_next;
            acc_reg  <= acc_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/clpc_queue.sv
// Small queue of result runs between front and back end
`default_nettype none
`include "compact_length_prefix_codec_assert.svh"
module clpc_queue #(
    parameter int DEPTH = clpc_pkg::QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire clpc_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output clpc_pkg::job_t      pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    clpc_pkg::job_t   entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = entries[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `CLPC_ASSERT(a_count_bound, aclk, aresetn, count_reg <= FULL_CNT)
    `CLPC_ASSERT(a_no_lost_push, aclk, aresetn, push |-> !full)
    `CLPC_ASSERT(a_pop_not_empty, aclk, aresetn, pop |-> !empty)

endmodule
`default_nettype wire

// File: hw/rtl/clpc_back.sv
// Back end: plays result runs out one byte per transfer
`default_nettype none
`include "compact_length_prefix_codec_assert.svh"
module clpc_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_empty,
    input  wire clpc_pkg::job_t q_job,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [7:0]          m_byte_out,
    output logic [31:0]         m_value_out,
    output logic                m_value_valid,
    output logic                m_last,
    output logic                m_header_error
);

    logic        m_valid_reg;
    logic [7:0]  byte_reg;
    logic [31:0] value_reg;
    logic        vvalid_reg, last_reg, err_reg;
    logic [39:0] cur_data_reg;
    logic [2:0]  cur_cnt_reg;
    logic        slot_free;

    assign slot_free = !m_valid_reg || m_ready;
    assign q_pop     = slot_free && (cur_cnt_reg == 3'd0) && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            cur_cnt_reg <= '0;
        end else if (slot_free) begin
            if (cur_cnt_reg != 3'd0) begin
                // rest of an encode run
                m_valid_reg  <= 1'b1;
                byte_reg     <= cur_data_reg[39:32];
                cur_data_reg <= {cur_data_reg[31:0], 8'h00};
                cur_cnt_reg  <= cur_cnt_reg - 3'd1;
                last_reg     <= (cur_cnt_reg == 3'd1);
                value_reg    <= '0;
                vvalid_reg   <= 1'b0;
                err_reg      <= 1'b0;
            end else if (!q_empty) begin
                m_valid_reg  <= 1'b1;
                byte_reg     <= q_job.data[39:32];
                cur_data_reg <= {q_job.data[31:0], 8'h00};
                cur_cnt_reg  <= q_job.cnt - 3'd1;
                last_reg     <= (q_job.cnt == 3'd1);
                value_reg    <= q_job.value;
                vvalid_reg   <= q_job.value_valid;
                err_reg      <= q_job.header_error;
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_byte_out     = byte_reg;
    assign m_value_out    = value_reg;
    assign m_value_valid  = vvalid_reg;
    assign m_last         = last_reg;
    assign m_header_error = err_reg;

    `CLPC_ASSERT(a_run_has_head, aclk, aresetn, (cur_cnt_reg != 3'd0) |-> m_valid_reg)
    `CLPC_ASSERT(a_value_is_last, aclk, aresetn, (m_valid_reg && vvalid_reg) |-> last_reg)
    `CLPC_ASSERT(a_err_no_value, aclk, aresetn, (m_valid_reg && err_reg) |-> !vvalid_reg)
    `CLPC_ASSERT(a_no_pop_mid_run, aclk, aresetn, q_pop |-> (cur_cnt_reg == 3'd0))

endmodule
`default_nettype wire

// File: hw/rtl/compact_length_prefix_codec.sv
// Length prefix codec: accepts one item per cycle while the run queue has room;
// decode yields 0 or 1 result. Encode yields a run of 1, 2, 4 or 5 bytes.
// The run queue registers an input, then the back end registers its first byte.
// Throughput: output is one byte per cycle from the back end while m_ready is
// high, so long encode runs fill the queue and stall the input.
// Reset (aresetn low, synchronous) empties the queue and clears format and decoder.
`default_nettype none
module compact_length_prefix_codec #(
    parameter int QUEUE_DEPTH = clpc_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [31:0] s_value_in,
    input  wire logic [7:0]  s_byte_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_byte_out,
    output logic [31:0]      m_value_out,
    output logic             m_value_valid,
    output logic             m_last,
    output logic             m_header_error,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data
);

    logic           q_push, q_full, q_pop, q_empty;
    clpc_pkg::job_t push_job, pop_job;

    clpc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_value_in  (s_value_in),
        .s_byte_in   (s_byte_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    clpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_job  (pop_job)
    );

    clpc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_job          (pop_job),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_out     (m_byte_out),
        .m_value_out    (m_value_out),
        .m_value_valid  (m_value_valid),
        .m_last         (m_last),
        .m_header_error (m_header_error)
    );

endmodule
`default_nettype wire
